FILE: src/rwd_pkg.sv
// ----------------------------------------------------------------------------
// rwd_pkg
// Shared types, codes and the 4-of-8 symbol table for the RailCom window
// decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rwd_pkg;

    localparam int unsigned NUM_BYTES = 8;

    typedef logic [6:0] t_sym;

    // special symbol codes; data values are 0x00..0x3F
    localparam t_sym SYM_ACK  = 7'h40;
    localparam t_sym SYM_NACK = 7'h41;
    localparam t_sym SYM_BUSY = 7'h42;
    localparam t_sym SYM_RSV  = 7'h43;
    localparam t_sym SYM_INV  = 7'h44;

    localparam logic [3:0] MOB_POM_ID = 4'd0;

    localparam logic [2:0] KIND_READ      = 3'd2;
    localparam logic [2:0] KIND_LONG_READ = 3'd3;

    localparam logic [7:0] MOB_HI_LOW  = 8'd192;
    localparam logic [7:0] MOB_HI_HIGH = 8'd231;

    typedef enum logic [2:0] {
        ST_POM     = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_CH2_BAD = 3'd2,
        ST_SPECIAL = 3'd3,
        ST_NO_POM  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CLS_NONE       = 2'd0,
        CLS_MOBILE     = 2'd1,
        CLS_STATIONARY = 2'd2
    } t_class;

    typedef struct packed {
        t_status     status;
        t_class      cls;
        logic        ch1_valid;
        logic [3:0]  ch1_identifier;
        logic [7:0]  ch1_payload;
        logic [3:0]  ch2_identifier;
        logic [31:0] pom_data;
    } t_result;

    // 4-of-8 line code to symbol
    function automatic t_sym sym_decode(input logic [7:0] b);
        t_sym s;
        case (b)
            8'h0F: s = SYM_NACK;
            8'h17: s = 7'h33;
            8'h1B: s = 7'h34;
            8'h1D: s = 7'h35;
            8'h1E: s = 7'h36;
            8'h27: s = 7'h3A;
            8'h2B: s = 7'h3B;
            8'h2D: s = 7'h3C;
            8'h2E: s = 7'h37;
            8'h33: s = 7'h3F;
            8'h35: s = 7'h3D;
            8'h36: s = 7'h38;
            8'h39: s = 7'h3E;
            8'h3A: s = 7'h39;
            8'h3C: s = SYM_RSV;
            8'h47: s = 7'h24;
            8'h4B: s = 7'h23;
            8'h4D: s = 7'h22;
            8'h4E: s = 7'h21;
            8'h53: s = 7'h1F;
            8'h55: s = 7'h1E;
            8'h56: s = 7'h20;
            8'h59: s = 7'h1D;
            8'h5A: s = 7'h1C;
            8'h5C: s = 7'h1B;
            8'h63: s = 7'h19;
            8'h65: s = 7'h18;
            8'h66: s = 7'h1A;
            8'h69: s = 7'h17;
            8'h6A: s = 7'h16;
            8'h6C: s = 7'h15;
            8'h71: s = 7'h25;
            8'h72: s = 7'h14;
            8'h74: s = 7'h13;
            8'h78: s = 7'h32;
            8'h87: s = SYM_RSV;
            8'h8B: s = 7'h0E;
            8'h8D: s = 7'h0D;
            8'h8E: s = 7'h0C;
            8'h93: s = 7'h0A;
            8'h95: s = 7'h09;
            8'h96: s = 7'h0B;
            8'h99: s = 7'h08;
            8'h9A: s = 7'h07;
            8'h9C: s = 7'h06;
            8'hA3: s = 7'h04;
            8'hA5: s = 7'h03;
            8'hA6: s = 7'h05;
            8'hA9: s = 7'h02;
            8'hAA: s = 7'h01;
            8'hAC: s = 7'h00;
            8'hB1: s = 7'h0F;
            8'hB2: s = 7'h10;
            8'hB4: s = 7'h11;
            8'hB8: s = 7'h12;
            8'hC3: s = SYM_RSV;
            8'hC5: s = 7'h2B;
            8'hC6: s = 7'h30;
            8'hC9: s = 7'h2A;
            8'hCA: s = 7'h2F;
            8'hCC: s = 7'h31;
            8'hD1: s = 7'h29;
            8'hD2: s = 7'h2E;
            8'hD4: s = 7'h2D;
            8'hD8: s = 7'h2C;
            8'hE1: s = SYM_BUSY;
            8'hE2: s = 7'h28;
            8'hE4: s = 7'h27;
            8'hE8: s = 7'h26;
            8'hF0: s = SYM_ACK;
            default: s = SYM_INV;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/rwd_decode.sv
// ----------------------------------------------------------------------------
// rwd_decode
// Symbol decode, channel 1/2 extraction, address class and POM assembly for
// one registered window.
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_decode (
    input  wire logic [rwd_pkg::NUM_BYTES-1:0][7:0] i_raw,
    input  wire logic [3:0]                         i_byte_count,
    input  wire logic [2:0]                         i_packet_kind,
    input  wire logic [7:0]                         i_addr_hi,
    output rwd_pkg::t_result                        o_result
);

    rwd_pkg::t_sym [rwd_pkg::NUM_BYTES-1:0] sym;
    logic [rwd_pkg::NUM_BYTES-1:0]          is_data;
    logic [rwd_pkg::NUM_BYTES-1:0][5:0]     bits6;
    logic                                   bad2;
    rwd_pkg::t_class                        cls;
    logic [3:0]                             ch2_id;

    // bytes past the count read as invalid; counts above eight cover all
    always_comb begin
        bad2 = 1'b0;
        for (int i = 0; i < rwd_pkg::NUM_BYTES; i++) begin
            sym[i]     = (i_byte_count > 4'(i)) ? rwd_pkg::sym_decode(i_raw[i])
                                                : rwd_pkg::SYM_INV;
            is_data[i] = ~sym[i][6];
            bits6[i]   = is_data[i] ? sym[i][5:0] : 6'd0;
            if (i > 1 && (sym[i] == rwd_pkg::SYM_INV || sym[i] == rwd_pkg::SYM_RSV)) begin
                bad2 = 1'b1;
            end
        end
    end

    always_comb begin
        if ((i_addr_hi != 8'd0 && !i_addr_hi[7]) ||
            (i_addr_hi >= rwd_pkg::MOB_HI_LOW && i_addr_hi <= rwd_pkg::MOB_HI_HIGH)) begin
            cls = rwd_pkg::CLS_MOBILE;
        end else if (i_addr_hi[7:6] == 2'b10) begin
            cls = rwd_pkg::CLS_STATIONARY;
        end else begin
            cls = rwd_pkg::CLS_NONE;
        end
    end

    assign ch2_id = sym[2][5:2];

    always_comb begin
        o_result = '0;
        if (i_byte_count == 4'd0) begin
            o_result.status = rwd_pkg::ST_EMPTY;
            o_result.cls    = rwd_pkg::CLS_NONE;
        end else begin
            o_result.cls = cls;
            if (is_data[0] && is_data[1]) begin
                o_result.ch1_valid      = 1'b1;
                o_result.ch1_identifier = sym[0][5:2];
                o_result.ch1_payload    = {sym[0][1:0], sym[1][5:0]};
            end
            if (bad2) begin
                o_result.status = rwd_pkg::ST_CH2_BAD;
            end else if (!is_data[2]) begin
                o_result.status = rwd_pkg::ST_SPECIAL;
            end else begin
                o_result.ch2_identifier = ch2_id;
                o_result.status         = rwd_pkg::ST_NO_POM;
                if (cls == rwd_pkg::CLS_MOBILE && ch2_id == rwd_pkg::MOB_POM_ID) begin
                    if (i_packet_kind <= rwd_pkg::KIND_READ) begin
                        o_result.pom_data = {24'd0, sym[2][1:0], bits6[3]};
                        o_result.status   = rwd_pkg::ST_POM;
                    end else if (i_packet_kind == rwd_pkg::KIND_LONG_READ) begin
                        o_result.pom_data = {sym[2][1:0], bits6[3], bits6[4],
                                             bits6[5], bits6[6], bits6[7]};
                        o_result.status   = rwd_pkg::ST_POM;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/railcom_window_decoder.sv
// ----------------------------------------------------------------------------
// railcom_window_decoder
// Decodes one RailCom cutout window into channel 1/2 fields and POM data.
// ----------------------------------------------------------------------------
// Usage:
//   Present the eight raw bytes, the byte count, packet kind, decoder
//   address and tag, and pulse start. A request is taken on any edge with
//   start high and busy low; busy never rises, so a window may be issued
//   every cycle.
//   The window is registered on entry, decoded through the symbol table
//   and assembly logic, and the result registered on exit. o_valid is high
//   for exactly one cycle per request, after the accept passes r_in_valid and
//   r_out_valid, with all result fields valid alongside it. Throughput is one
//   window per clock; the path holds two registers, entry and exit.
//   The receiver cannot hold results off: each one is valid on the ports for that
//   single cycle only. Synchronous reset drops any request in flight and
//   clears o_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module railcom_window_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_raw_byte_0,
    input  wire logic [7:0]  i_raw_byte_1,
    input  wire logic [7:0]  i_raw_byte_2,
    input  wire logic [7:0]  i_raw_byte_3,
    input  wire logic [7:0]  i_raw_byte_4,
    input  wire logic [7:0]  i_raw_byte_5,
    input  wire logic [7:0]  i_raw_byte_6,
    input  wire logic [7:0]  i_raw_byte_7,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic [2:0]  i_packet_kind,
    input  wire logic [15:0] i_decoder_address,
    input  wire logic [15:0] i_transaction_tag,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [1:0]       o_instruction_class,
    output logic             o_ch1_valid,
    output logic [3:0]       o_ch1_identifier,
    output logic [7:0]       o_ch1_payload,
    output logic [3:0]       o_ch2_identifier,
    output logic [31:0]      o_pom_data,
    output logic [15:0]      o_transaction_id
);

    logic                                   r_in_valid;
    logic [rwd_pkg::NUM_BYTES-1:0][7:0]     r_raw;
    logic [3:0]                             r_byte_count;
    logic [2:0]                             r_packet_kind;
    logic [7:0]                             r_addr_hi;
    logic [15:0]                            r_tag;

    logic                                   r_out_valid;
    rwd_pkg::t_result                       r_result;
    logic [15:0]                            r_out_tag;

    rwd_pkg::t_result                       n_result;
    logic                                   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw         <= {i_raw_byte_7, i_raw_byte_6, i_raw_byte_5, i_raw_byte_4,
                              i_raw_byte_3, i_raw_byte_2, i_raw_byte_1, i_raw_byte_0};
            r_byte_count  <= i_byte_count;
            r_packet_kind <= i_packet_kind;
            r_addr_hi     <= i_decoder_address[15:8];
            r_tag         <= i_transaction_tag;
        end
    end

    rwd_decode u_decode (
        .i_raw         (r_raw),
        .i_byte_count  (r_byte_count),
        .i_packet_kind (r_packet_kind),
        .i_addr_hi     (r_addr_hi),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result  <= n_result;
            r_out_tag <= r_tag;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_result.status;
    assign o_instruction_class = r_result.cls;
    assign o_ch1_valid         = r_result.ch1_valid;
    assign o_ch1_identifier    = r_result.ch1_identifier;
    assign o_ch1_payload       = r_result.ch1_payload;
    assign o_ch2_identifier    = r_result.ch2_identifier;
    assign o_pom_data          = r_result.pom_data;
    assign o_transaction_id    = r_out_tag;

    // one result per request through the input and output registers, tag carried alongside
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 (o_valid && o_transaction_id == $past(i_transaction_tag, 2)))
        else $error("request did not produce its result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_in_valid))
        else $error("result without a request");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rwd_pkg::ST_EMPTY) |->
            (o_instruction_class == rwd_pkg::CLS_NONE && !o_ch1_valid &&
             o_ch2_identifier == 4'd0 && o_pom_data == 32'd0))
        else $error("empty window carries data");

    a_pom_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rwd_pkg::ST_POM) |-> o_pom_data == 32'd0)
        else $error("POM data outside a POM response");

    a_pom_mobile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rwd_pkg::ST_POM) |->
            (o_instruction_class == rwd_pkg::CLS_MOBILE &&
             o_ch2_identifier == rwd_pkg::MOB_POM_ID))
        else $error("POM response for a non-mobile or non-POM window");

    a_ch1_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ch1_valid) |->
            (o_ch1_identifier == 4'd0 && o_ch1_payload == 8'd0))
        else $error("channel 1 fields set without valid data");

endmodule

`default_nettype wire

FILE: tb/rwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwd_checker
// Watches the request and result ports of the RailCom window decoder,
// decodes every accepted window on its own and compares each strobed result
// field by field with the oldest outstanding window.
// ----------------------------------------------------------------------------

module rwd_checker
    import rwd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [63:0] i_window,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic [2:0]  i_packet_kind,
    input  wire logic [15:0] i_decoder_address,
    input  wire logic [15:0] i_transaction_tag,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_status,
    input  wire logic [1:0]  i_instruction_class,
    input  wire logic        i_ch1_valid,
    input  wire logic [3:0]  i_ch1_identifier,
    input  wire logic [7:0]  i_ch1_payload,
    input  wire logic [3:0]  i_ch2_identifier,
    input  wire logic [31:0] i_pom_data,
    input  wire logic [15:0] i_transaction_id,
    output int               o_fail_count,
    output int               o_pending
);

    // line code for each data value, value 0x00 first
    localparam logic [8*64-1:0] DATA_CODES = {
        8'hAC, 8'hAA, 8'hA9, 8'hA5, 8'hA3, 8'hA6, 8'h9C, 8'h9A,
        8'h99, 8'h95, 8'h93, 8'h96, 8'h8E, 8'h8D, 8'h8B, 8'hB1,
        8'hB2, 8'hB4, 8'hB8, 8'h74, 8'h72, 8'h6C, 8'h6A, 8'h69,
        8'h65, 8'h63, 8'h66, 8'h5C, 8'h5A, 8'h59, 8'h55, 8'h53,
        8'h56, 8'h4E, 8'h4D, 8'h4B, 8'h47, 8'h71, 8'hE8, 8'hE4,
        8'hE2, 8'hD1, 8'hC9, 8'hC5, 8'hD8, 8'hD4, 8'hD2, 8'hCA,
        8'hC6, 8'hCC, 8'h78, 8'h17, 8'h1B, 8'h1D, 8'h1E, 8'h2E,
        8'h36, 8'h3A, 8'h27, 8'h2B, 8'h2D, 8'h35, 8'h39, 8'h33
    };

    localparam logic [7:0] CODE_ACK   = 8'hF0;
    localparam logic [7:0] CODE_NACK  = 8'h0F;
    localparam logic [7:0] CODE_BUSY  = 8'hE1;
    localparam logic [7:0] CODE_RSV_A = 8'h3C;
    localparam logic [7:0] CODE_RSV_B = 8'h87;
    localparam logic [7:0] CODE_RSV_C = 8'hC3;

    typedef struct packed {
        t_status     status;
        t_class      cls;
        logic        ch1_valid;
        logic [3:0]  ch1_id;
        logic [7:0]  ch1_payload;
        logic [3:0]  ch2_id;
        logic [31:0] pom;
        logic [15:0] tag;
    } t_window_report;

    t_sym           sym_of_code [256];
    t_window_report expected_reports [$];

    initial begin
        for (int c = 0; c < 256; c++)
            sym_of_code[c] = SYM_INV;
        for (int v = 0; v < 64; v++)
            sym_of_code[DATA_CODES[8*(63-v) +: 8]] = t_sym'(v);
        sym_of_code[CODE_ACK]   = SYM_ACK;
        sym_of_code[CODE_NACK]  = SYM_NACK;
        sym_of_code[CODE_BUSY]  = SYM_BUSY;
        sym_of_code[CODE_RSV_A] = SYM_RSV;
        sym_of_code[CODE_RSV_B] = SYM_RSV;
        sym_of_code[CODE_RSV_C] = SYM_RSV;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // specials contribute zero bits to the POM payload
    function automatic logic [5:0] payload_bits(input t_sym s);
        return s[6] ? 6'd0 : s[5:0];
    endfunction

    function automatic t_window_report decode_window(
        input logic [63:0] bytes,
        input logic [3:0]  count_in,
        input logic [2:0]  kind,
        input logic [15:0] addr,
        input logic [15:0] tag
    );
        t_window_report r;
        t_sym           s [8];
        logic [3:0]     n;
        logic [7:0]     hi;
        logic           ch2_bad;

        r       = '0;
        r.tag   = tag;
        n       = (count_in > 4'd8) ? 4'd8 : count_in;
        hi      = addr[15:8];
        ch2_bad = 1'b0;

        if ((hi >= 8'd1 && hi <= 8'd127) || (hi >= 8'd192 && hi <= 8'd231))
            r.cls = CLS_MOBILE;
        else if (hi >= 8'd128 && hi <= 8'd191)
            r.cls = CLS_STATIONARY;
        else
            r.cls = CLS_NONE;

        // bytes past the count read as invalid
        for (int i = 0; i < 8; i++) begin
            s[i] = (i < n) ? sym_of_code[bytes[8*i +: 8]] : SYM_INV;
            if (i >= 2 && (s[i] == SYM_INV || s[i] == SYM_RSV))
                ch2_bad = 1'b1;
        end

        if (n == 4'd0) begin
            r.status = ST_EMPTY;
            r.cls    = CLS_NONE;
        end else begin
            if (!s[0][6] && !s[1][6]) begin
                r.ch1_valid   = 1'b1;
                r.ch1_id      = s[0][5:2];
                r.ch1_payload = {s[0][1:0], s[1][5:0]};
            end
            if (ch2_bad) begin
                r.status = ST_CH2_BAD;
            end else if (s[2][6]) begin
                r.status = ST_SPECIAL;
            end else begin
                r.ch2_id = s[2][5:2];
                r.status = ST_NO_POM;
                if (r.cls == CLS_MOBILE && r.ch2_id == MOB_POM_ID) begin
                    if (kind <= KIND_READ) begin
                        r.pom    = {24'd0, s[2][1:0], payload_bits(s[3])};
                        r.status = ST_POM;
                    end else if (kind == KIND_LONG_READ) begin
                        r.pom    = {s[2][1:0], payload_bits(s[3]), payload_bits(s[4]),
                                    payload_bits(s[5]), payload_bits(s[6]),
                                    payload_bits(s[7])};
                        r.status = ST_POM;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_window_report want;
        if (i_rst_n && i_start && !i_busy)
            expected_reports.push_back(decode_window(i_window, i_byte_count, i_packet_kind,
                                                     i_decoder_address, i_transaction_tag));
        if (i_rst_n && i_valid) begin
            if (expected_reports.size() == 0) begin
                $error("result with no request outstanding, id 0x%0h", i_transaction_id);
                o_fail_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("status",            want.status,      i_status);
                check_field("instruction_class", want.cls,         i_instruction_class);
                check_field("ch1_valid",         want.ch1_valid,   i_ch1_valid);
                check_field("ch1_identifier",    want.ch1_id,      i_ch1_identifier);
                check_field("ch1_payload",       want.ch1_payload, i_ch1_payload);
                check_field("ch2_identifier",    want.ch2_id,      i_ch2_identifier);
                check_field("pom_data",          want.pom,         i_pom_data);
                check_field("transaction_id",    want.tag,         i_transaction_id);
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives cutout windows into the RailCom window decoder in random bursts:
// a directed set covering the special cases, then mostly well-formed POM
// windows with random content mixed with noise. The checker does the rest.
// ----------------------------------------------------------------------------

module tb_top;
    import rwd_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] CODE_ACK      = 8'hF0;
    localparam logic [7:0] CODE_NACK     = 8'h0F;
    localparam logic [7:0] CODE_BUSY     = 8'hE1;
    localparam logic [7:0] CODE_RSV      = 8'h3C;
    localparam logic [7:0] CODE_RSV_ALT  = 8'h87;
    localparam logic [7:0] CODE_RSV_LAST = 8'hC3;
    localparam logic [7:0] CODE_BAD      = 8'hFF;
    localparam logic [7:0] CODE_ZERO     = 8'hAC;  // data value 0x00
    localparam logic [7:0] CODE_ONES     = 8'h33;  // data value 0x3F

    // data values 0..3 carry channel 2 identifier 0
    localparam logic [31:0] POM_ID_CODES = {8'hA5, 8'hA9, 8'hAA, 8'hAC};

    localparam logic [2:0] KIND_BIT_WRITE  = 3'd0;
    localparam logic [2:0] KIND_BYTE_WRITE = 3'd1;
    localparam logic [2:0] KIND_OTHER      = 3'd4;
    localparam logic [2:0] KIND_TOP        = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    wire         busy;
    logic [63:0] window;
    logic [3:0]  byte_count;
    logic [2:0]  packet_kind;
    logic [15:0] decoder_address;
    logic [15:0] transaction_tag;

    wire         o_valid;
    wire [2:0]   o_status;
    wire [1:0]   o_instruction_class;
    wire         o_ch1_valid;
    wire [3:0]   o_ch1_identifier;
    wire [7:0]   o_ch1_payload;
    wire [3:0]   o_ch2_identifier;
    wire [31:0]  o_pom_data;
    wire [15:0]  o_transaction_id;

    int          fail_count;
    int          pending;
    int          burst_left;

    railcom_window_decoder uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_raw_byte_0        (window[7:0]),
        .i_raw_byte_1        (window[15:8]),
        .i_raw_byte_2        (window[23:16]),
        .i_raw_byte_3        (window[31:24]),
        .i_raw_byte_4        (window[39:32]),
        .i_raw_byte_5        (window[47:40]),
        .i_raw_byte_6        (window[55:48]),
        .i_raw_byte_7        (window[63:56]),
        .i_byte_count        (byte_count),
        .i_packet_kind       (packet_kind),
        .i_decoder_address   (decoder_address),
        .i_transaction_tag   (transaction_tag),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_instruction_class (o_instruction_class),
        .o_ch1_valid         (o_ch1_valid),
        .o_ch1_identifier    (o_ch1_identifier),
        .o_ch1_payload       (o_ch1_payload),
        .o_ch2_identifier    (o_ch2_identifier),
        .o_pom_data          (o_pom_data),
        .o_transaction_id    (o_transaction_id)
    );

    rwd_checker monitor (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_window            (window),
        .i_byte_count        (byte_count),
        .i_packet_kind       (packet_kind),
        .i_decoder_address   (decoder_address),
        .i_transaction_tag   (transaction_tag),
        .i_valid             (o_valid),
        .i_status            (o_status),
        .i_instruction_class (o_instruction_class),
        .i_ch1_valid         (o_ch1_valid),
        .i_ch1_identifier    (o_ch1_identifier),
        .i_ch1_payload       (o_ch1_payload),
        .i_ch2_identifier    (o_ch2_identifier),
        .i_pom_data          (o_pom_data),
        .i_transaction_id    (o_transaction_id),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("railcom_window_decoder: mismatch");
        $finish;
    end

    // any 4-of-8 line code: data values and specials alike
    function automatic logic [7:0] line_symbol();
        logic [7:0] b;
        do b = 8'($urandom); while ($countones(b) != 4);
        return b;
    endfunction

    function automatic logic [7:0] data_symbol();
        logic [7:0] b;
        do b = line_symbol();
        while (b == CODE_ACK || b == CODE_NACK || b == CODE_BUSY || b == CODE_RSV ||
               b == CODE_RSV_ALT || b == CODE_RSV_LAST);
        return b;
    endfunction

    function automatic logic [15:0] mobile_address();
        logic [7:0] hi;
        hi = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 127))
                                         : 8'($urandom_range(192, 231));
        return {hi, 8'($urandom)};
    endfunction

    // channel 1 and mostly a POM lead byte, payload mostly data with odd specials
    function automatic logic [63:0] pom_window();
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = ($urandom_range(0, 9) == 0) ? line_symbol() : data_symbol();
        if ($urandom_range(0, 4) != 0)
            w[23:16] = POM_ID_CODES[8*$urandom_range(0, 3) +: 8];
        return w;
    endfunction

    function automatic logic [63:0] set_byte(input logic [63:0] w, input int idx,
                                             input logic [7:0] b);
        w[8*idx +: 8] = b;
        return w;
    endfunction

    // bursts of requests with random idle stretches in between
    task automatic send_window(input logic [63:0] bytes, input logic [3:0] count_in,
                               input logic [2:0] kind, input logic [15:0] addr,
                               input logic [15:0] tag);
        int gap;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        window          <= bytes;
        byte_count      <= count_in;
        packet_kind     <= kind;
        decoder_address <= addr;
        transaction_tag <= tag;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    initial begin
        logic [63:0] base;
        logic [7:0]  class_hi [7];

        i_rst_n         = 1'b0;
        start           = 1'b0;
        window          = '0;
        byte_count      = '0;
        packet_kind     = '0;
        decoder_address = '0;
        transaction_tag = '0;
        burst_left      = 0;
        class_hi        = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hE7, 8'hE8};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // POM lead with value 0, payload all ones
        base = {{5{CODE_ONES}}, CODE_ZERO, data_symbol(), data_symbol()};

        send_window(64'($urandom) << 32, 4'd0, KIND_TOP, 16'hFFFF, 16'h0000);
        send_window(base, 4'd8, KIND_LONG_READ, 16'h0100, 16'hFFFF);
        send_window(base, 4'd8, KIND_BIT_WRITE, 16'h01FF, 16'h0001);
        send_window(base, 4'd8, KIND_BYTE_WRITE, 16'h7F00, 16'h0002);
        send_window(base, 4'd8, KIND_READ, 16'hC000, 16'h0003);
        send_window(base, 4'd8, KIND_OTHER, 16'hE7AA, 16'h0004);
        send_window(base, 4'd8, KIND_TOP, 16'h4455, 16'h0005);
        send_window(base, 4'd15, KIND_READ, 16'h2000, 16'h0006);
        send_window(base, 4'd7, KIND_LONG_READ, 16'h2000, 16'h0007);
        // channel 1 corrupted by a special and by a non-code byte
        send_window(set_byte(base, 0, CODE_NACK), 4'd8, KIND_READ, 16'h0300, 16'h0008);
        send_window(set_byte(base, 1, 8'h00), 4'd8, KIND_LONG_READ, 16'h0300, 16'h0009);
        // channel 2 spoilt by reserved or invalid codes, or led by a special
        send_window(set_byte(base, 5, CODE_RSV), 4'd8, KIND_LONG_READ, 16'h0300, 16'h000A);
        send_window(set_byte(base, 7, CODE_BAD), 4'd8, KIND_LONG_READ, 16'h0300, 16'h000B);
        send_window(set_byte(base, 2, CODE_ACK), 4'd8, KIND_READ, 16'h0300, 16'h000C);
        send_window(set_byte(base, 2, CODE_NACK), 4'd8, KIND_READ, 16'h0300, 16'h000D);
        send_window(set_byte(base, 2, CODE_BUSY), 4'd8, KIND_READ, 16'h0300, 16'h000E);
        // acknowledge inside the payload adds zeros
        send_window(set_byte(base, 4, CODE_ACK), 4'd8, KIND_LONG_READ, 16'h0300, 16'h000F);
        // non-POM identifier on channel 2
        send_window(set_byte(base, 2, CODE_ONES), 4'd8, KIND_READ, 16'h0300, 16'h0010);
        for (int k = 0; k < 7; k++)
            send_window(base, 4'd8, KIND_LONG_READ, {class_hi[k], 8'h5A}, 16'(17 + k));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 3) != 0)
                send_window(pom_window(),
                            ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'd8,
                            ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                        : 3'($urandom_range(0, 3)),
                            ($urandom_range(0, 6) == 0) ? 16'($urandom) : mobile_address(),
                            16'($urandom));
            else
                send_window({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                            3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
        end
        start <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("railcom_window_decoder: match");
        else
            $display("railcom_window_decoder: mismatch");
        $finish;
    end

endmodule
